// File: sv/html_numeric_entity_escaper_top_assert.svh
// Assertion macros shared by the escaper's checker.
// No dependencies; take in by `include with the bare file name.
`ifndef HTML_NUMERIC_ENTITY_ESCAPER_TOP_ASSERT_SVH
`define HTML_NUMERIC_ENTITY_ESCAPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HNE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HNE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hne_pkg.sv
// Shared types, character codes and the escape-set decoder of the escaper.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hne_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned ValW = 14;

  typedef logic [CpW-1:0]  cp_t;
  typedef logic [ValW-1:0] val_t;
  typedef logic [3:0]      digit_t;

  localparam cp_t CharAmp  = 21'd38;
  localparam cp_t CharHash = 21'd35;
  localparam cp_t CharSemi = 21'd59;
  localparam cp_t CharZero = 21'd48;

  // One queued word: either a passthrough point or the digits of a reference.
  typedef struct packed {
    logic             esc;
    cp_t              cp;
    digit_t [3:0]     dig;   // dig[3] is the thousands digit
    logic   [2:0]     ndig;  // 2 to 4 digits
  } entry_t;

  function automatic logic in_escape_set(cp_t cp);
    logic hit;
    unique case (cp) inside
      21'd34, 21'd38, 21'd39, 21'd60, 21'd62:          hit = 1'b1;
      [21'd160:21'd255]:                               hit = 1'b1;
      21'd338, 21'd339, 21'd352, 21'd353, 21'd376:     hit = 1'b1;
      21'd710, 21'd732:                                hit = 1'b1;
      21'd8194, 21'd8195, 21'd8201:                    hit = 1'b1;
      [21'd8204:21'd8207], 21'd8211, 21'd8212:         hit = 1'b1;
      [21'd8216:21'd8218], [21'd8220:21'd8222]:        hit = 1'b1;
      21'd8224, 21'd8225, 21'd8230, 21'd8240:          hit = 1'b1;
      21'd8249, 21'd8250, 21'd8364, 21'd8482:          hit = 1'b1;
      default:                                         hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: sv/hne_front.sv
// Front end: accepts a code point, classifies it and splits it into digits.
// Depends on hne_pkg.
`timescale 1ns / 1ps

module hne_front
  import hne_pkg::*;
(
  input  logic   start,
  input  logic   full_i,
  input  cp_t    code_point_i,
  output logic   busy,
  output logic   push_o,
  output entry_t entry_o
);

  // Reciprocals exact for values up to 8482.
  localparam logic [27:0] Recip10   = 28'd6554;  // >> 16
  localparam logic [27:0] Recip100  = 28'd5243;  // >> 19
  localparam logic [27:0] Recip1000 = 28'd8389;  // >> 23

  val_t        val;
  logic [27:0] prod10, prod100, prod1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  val_t        rem0;
  logic [9:0]  rem1;
  logic [6:0]  rem2;

  assign busy   = full_i;
  assign push_o = start && !full_i;

  assign val      = code_point_i[ValW-1:0];
  assign prod10   = 28'(val) * Recip10;
  assign prod100  = 28'(val) * Recip100;
  assign prod1000 = 28'(val) * Recip1000;
  assign q10      = prod10[25:16];
  assign q100     = prod100[25:19];
  assign q1000    = prod1000[26:23];

  assign rem0 = val - ValW'(q10) * 14'd10;
  assign rem1 = q10 - 10'(q100) * 10'd10;
  assign rem2 = q100 - 7'(q1000) * 7'd10;

  always_comb begin
    entry_o.esc    = in_escape_set(code_point_i);
    entry_o.cp     = code_point_i;
    entry_o.dig[0] = rem0[3:0];
    entry_o.dig[1] = rem1[3:0];
    entry_o.dig[2] = rem2[3:0];
    entry_o.dig[3] = q1000;
    if (val >= 14'd1000) begin
      entry_o.ndig = 3'd4;
    end else if (val >= 14'd100) begin
      entry_o.ndig = 3'd3;
    end else begin
      entry_o.ndig = 3'd2;
    end
  end

endmodule

// File: sv/hne_queue.sv
// Short register queue between the front and back ends.
// Depends on hne_pkg for the word type.
`timescale 1ns / 1ps

module hne_queue
  import hne_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: sv/hne_back.sv
// Back end: walks the head word one output character per cycle while the queue is not empty.
// Depends on hne_pkg.
`timescale 1ns / 1ps

module hne_back
  import hne_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   empty_i,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   strobe_o,
  output cp_t    out_char_o,
  output logic   last_of_run_o
);

  logic [2:0] pos_q, pos_d;
  logic [2:0] sel_full;
  logic [1:0] sel;
  logic       strobe_q;
  cp_t        char_q, char_d;
  logic       last_q, last_d;

  // Digits go out most significant first.
  assign sel_full = head_i.ndig + 3'd1 - pos_q;
  assign sel      = sel_full[1:0];

  always_comb begin
    last_d = 1'b0;
    char_d = CharZero + CpW'(head_i.dig[sel]);
    if (!head_i.esc) begin
      char_d = head_i.cp;
      last_d = 1'b1;
    end else if (pos_q == 3'd0) begin
      char_d = CharAmp;
    end else if (pos_q == 3'd1) begin
      char_d = CharHash;
    end else if (pos_q == head_i.ndig + 3'd2) begin
      char_d = CharSemi;
      last_d = 1'b1;
    end
    pop_o = !empty_i && last_d;
    pos_d = pos_q;
    if (!empty_i) begin
      pos_d = last_d ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      strobe_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      strobe_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!empty_i) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign strobe_o      = strobe_q;
  assign out_char_o    = char_q;
  assign last_of_run_o = last_q;

endmodule

// File: sv/html_numeric_entity_escaper_top.sv
// Top level of the numeric character reference escaper.
// Depends on hne_pkg, hne_front, hne_queue and hne_back.
`timescale 1ns / 1ps

// Usage:
//   Input: drive code_point_i and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy is high only while the
//   internal queue is full.
//   Output: each character appears on out_char_o for one cycle with strobe_o
//   high; last_of_run_o marks the final character caused by one input.
//   A code point in the escape set yields '&', '#', its decimal digits and
//   ';' (5 to 7 characters on consecutive cycles); any other code point
//   passes through as one character.
//   Path: an accepted word is written into a queue slot, and its first
//   character is then registered in the back end before it appears.
//   Throughput: one character per cycle while the queue is not empty, set by
//   the back end that emits one character per clock; passthrough points flow
//   at one per cycle, an escaped point holds the back end for its whole run.
//   Reset: clears the queue and the output strobe; busy is low after reset.
//   The receiver cannot stall; every strobe must be taken.

module html_numeric_entity_escaper_top
  import hne_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cp_t  code_point_i,
  output logic strobe_o,
  output cp_t  out_char_o,
  output logic last_of_run_o
);

  logic   push, pop, full, empty;
  entry_t front_word, head_word;

  hne_front u_front (
    .start        (start),
    .full_i       (full),
    .code_point_i (code_point_i),
    .busy         (busy),
    .push_o       (push),
    .entry_o      (front_word)
  );

  hne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_word),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_word)
  );

  hne_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_word),
    .pop_o         (pop),
    .strobe_o      (strobe_o),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: sv/hne_checker.sv
// Port-level checks on the escaper's output runs, bound to the top level.
// Depends on hne_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "html_numeric_entity_escaper_top_assert.svh"

module hne_checker
  import hne_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic strobe_o,
  input cp_t  out_char_o,
  input logic last_of_run_o
);

  logic mid_run, mid_run_q;
  logic run_open, is_ascii, amp_mid, hash_mid;

  assign mid_run  = strobe_o && !last_of_run_o;
  assign run_open = mid_run && !mid_run_q;
  assign is_ascii = (out_char_o[CpW-1:7] == '0);
  assign amp_mid  = mid_run && (out_char_o == CharAmp);
  assign hash_mid = mid_run && (out_char_o == CharHash);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q <= 1'b0;
    end else begin
      mid_run_q <= mid_run;
    end
  end

  // A reference run goes out without gaps.
  `HNE_ASSERT_NEXT(a_run_no_gap, clk_i, rst_ni, mid_run, strobe_o, "gap inside a run")

  // Every non-final character of a run is ASCII.
  `HNE_ASSERT_NOW(a_run_ascii, clk_i, rst_ni, mid_run, is_ascii, "non-ASCII in run")

  // A multi-character run opens with an ampersand.
  `HNE_ASSERT_NOW(a_run_opens_amp, clk_i, rst_ni, run_open, amp_mid, "run opens without '&'")

  // The ampersand is followed by a hash sign.
  `HNE_ASSERT_NEXT(a_amp_then_hash, clk_i, rst_ni, amp_mid, hash_mid, "no '#' after '&'")

endmodule

bind html_numeric_entity_escaper_top hne_checker u_hne_checker (.*);
